FILE: design/mlr_pkg.sv
// Shared types and constants for the midpoint line rasterizer.
package mlr_pkg;

    localparam int COORD_W     = 12;
    localparam int DEC_W       = COORD_W + 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [COORD_W:0]   delta_t;
    typedef logic signed [DEC_W-1:0]   dec_t;

    typedef struct packed {
        logic   is_step;
        coord_t cur_x;
        coord_t cur_y;
        coord_t major_end;
        dec_t   decision;
        dec_t   step_inc;
        dec_t   stay_dec;
        logic   steep;
        logic   y_down;
    } seg_cmd_t;

endpackage

FILE: design/mlr_in_if.sv
// Input channel carrying load and step items.
interface mlr_in_if;
    import mlr_pkg::*;

    logic   valid;
    logic   ready;
    logic   operation;
    coord_t x_start;
    coord_t y_start;
    coord_t x_end;
    coord_t y_end;

    modport source (output valid, operation, x_start, y_start, x_end, y_end, input ready);
    modport sink   (input valid, operation, x_start, y_start, x_end, y_end, output ready);
endinterface

FILE: design/mlr_out_if.sv
// Output channel carrying one pixel result per item.
interface mlr_out_if;
    import mlr_pkg::*;

    logic   valid;
    logic   ready;
    logic   pixel_valid;
    coord_t pixel_x;
    coord_t pixel_y;
    logic   last_pixel;

    modport source (output valid, pixel_valid, pixel_x, pixel_y, last_pixel, input ready);
    modport sink   (input valid, pixel_valid, pixel_x, pixel_y, last_pixel, output ready);
endinterface

FILE: design/mlr_front.sv
// Front end: orders endpoints and computes the segment setup.
module mlr_front (
    input  logic              clk,
    input  logic              rst_n,
    mlr_in_if.sink            cmd,
    output logic              wr_valid,
    input  logic              wr_ready,
    output mlr_pkg::seg_cmd_t wr_data
);
    import mlr_pkg::*;

    logic   stage_valid_reg, stage_valid_next;
    logic   stage_op_reg;
    coord_t stage_xa_reg, stage_ya_reg, stage_xb_reg, stage_yb_reg;
    delta_t stage_dx_reg, stage_dy_reg;

    logic   take;
    logic   swap;
    coord_t xa, ya, xb, yb;
    delta_t ady, maj, mn;
    logic   steep;

    assign cmd.ready = !stage_valid_reg || wr_ready;
    assign take      = cmd.valid && cmd.ready;

    always_comb
    begin
        swap = cmd.x_start > cmd.x_end;
        xa   = swap ? cmd.x_end   : cmd.x_start;
        ya   = swap ? cmd.y_end   : cmd.y_start;
        xb   = swap ? cmd.x_start : cmd.x_end;
        yb   = swap ? cmd.y_start : cmd.y_end;
    end

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (take)
        begin
            stage_valid_next = 1'b1;
        end
        else if (wr_ready)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            stage_op_reg <= cmd.operation;
            stage_xa_reg <= xa;
            stage_ya_reg <= ya;
            stage_xb_reg <= xb;
            stage_yb_reg <= yb;
            stage_dx_reg <= delta_t'(xb) - delta_t'(xa);
            stage_dy_reg <= delta_t'(yb) - delta_t'(ya);
        end
    end

    always_comb
    begin
        ady   = stage_dy_reg[COORD_W] ? -stage_dy_reg : stage_dy_reg;
        steep = ady > stage_dx_reg;
        maj   = steep ? ady : stage_dx_reg;
        mn    = steep ? stage_dx_reg : ady;

        wr_data.is_step   = (stage_op_reg == OP_STEP);
        wr_data.cur_x     = stage_xa_reg;
        wr_data.cur_y     = stage_ya_reg;
        wr_data.major_end = steep ? stage_yb_reg : stage_xb_reg;
        wr_data.decision  = dec_t'(maj) - (dec_t'(mn) <<< 1);
        wr_data.step_inc  = (dec_t'(maj) <<< 1) - (dec_t'(mn) <<< 1);
        wr_data.stay_dec  = dec_t'(mn) <<< 1;
        wr_data.steep     = steep;
        wr_data.y_down    = stage_dy_reg[COORD_W];
    end

    assign wr_valid = stage_valid_reg;

endmodule

FILE: design/mlr_queue.sv
// Short queue of prepared items between the front and back ends.
module mlr_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_valid,
    output logic              wr_ready,
    input  mlr_pkg::seg_cmd_t wr_data,
    output logic              rd_valid,
    input  logic              rd_ready,
    output mlr_pkg::seg_cmd_t rd_data
);
    import mlr_pkg::*;

    seg_cmd_t            entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]     count_reg, count_next;
    logic                push, pop;

    assign wr_ready = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: design/mlr_back.sv
// Back end: steps the decision value and registers one pixel result per item.
module mlr_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_valid,
    output logic              rd_ready,
    input  mlr_pkg::seg_cmd_t rd_data,
    mlr_out_if.source         pix
);
    import mlr_pkg::*;

    coord_t cur_x_reg, cur_x_next;
    coord_t cur_y_reg, cur_y_next;
    coord_t major_end_reg, major_end_next;
    dec_t   decision_reg, decision_next;
    dec_t   step_inc_reg, step_inc_next;
    dec_t   stay_dec_reg, stay_dec_next;
    logic   steep_reg, steep_next;
    logic   y_down_reg, y_down_next;
    logic   drawing_reg, drawing_next;

    logic   out_valid_reg, out_valid_next;
    logic   pixel_valid_reg, pixel_valid_next;
    coord_t pixel_x_reg, pixel_x_next;
    coord_t pixel_y_reg, pixel_y_next;
    logic   last_reg, last_next;

    logic   pop;
    logic   at_end;
    coord_t y_stepped;
    logic   minor_step;

    assign rd_ready = !out_valid_reg || pix.ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        major_end_next   = major_end_reg;
        decision_next    = decision_reg;
        step_inc_next    = step_inc_reg;
        stay_dec_next    = stay_dec_reg;
        steep_next       = steep_reg;
        y_down_next      = y_down_reg;
        drawing_next     = drawing_reg;
        out_valid_next   = out_valid_reg;
        pixel_valid_next = pixel_valid_reg;
        pixel_x_next     = pixel_x_reg;
        pixel_y_next     = pixel_y_reg;
        last_next        = last_reg;

        at_end     = (steep_reg ? cur_y_reg : cur_x_reg) == major_end_reg;
        y_stepped  = y_down_reg ? cur_y_reg - coord_t'(1) : cur_y_reg + coord_t'(1);
        minor_step = decision_reg[DEC_W-1];

        if (out_valid_reg && pix.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (pop)
        begin
            out_valid_next   = 1'b1;
            pixel_valid_next = 1'b0;
            pixel_x_next     = '0;
            pixel_y_next     = '0;
            last_next        = 1'b0;
            priority if (!rd_data.is_step)
            begin
                cur_x_next     = rd_data.cur_x;
                cur_y_next     = rd_data.cur_y;
                major_end_next = rd_data.major_end;
                decision_next  = rd_data.decision;
                step_inc_next  = rd_data.step_inc;
                stay_dec_next  = rd_data.stay_dec;
                steep_next     = rd_data.steep;
                y_down_next    = rd_data.y_down;
                drawing_next   = 1'b1;
            end
            else if (drawing_reg)
            begin
                pixel_valid_next = 1'b1;
                pixel_x_next     = cur_x_reg;
                pixel_y_next     = cur_y_reg;
                last_next        = at_end;
                if (at_end)
                begin
                    drawing_next = 1'b0;
                end
                else
                begin
                    decision_next = minor_step ? decision_reg + step_inc_reg
                                               : decision_reg - stay_dec_reg;
                    if (steep_reg)
                    begin
                        cur_y_next = y_stepped;
                        if (minor_step)
                        begin
                            cur_x_next = cur_x_reg + coord_t'(1);
                        end
                    end
                    else
                    begin
                        cur_x_next = cur_x_reg + coord_t'(1);
                        if (minor_step)
                        begin
                            cur_y_next = y_stepped;
                        end
                    end
                end
            end
            else
            begin
                drawing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            major_end_reg   <= '0;
            decision_reg    <= '0;
            step_inc_reg    <= '0;
            stay_dec_reg    <= '0;
            steep_reg       <= 1'b0;
            y_down_reg      <= 1'b0;
            drawing_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            cur_x_reg       <= cur_x_next;
            cur_y_reg       <= cur_y_next;
            major_end_reg   <= major_end_next;
            decision_reg    <= decision_next;
            step_inc_reg    <= step_inc_next;
            stay_dec_reg    <= stay_dec_next;
            steep_reg       <= steep_next;
            y_down_reg      <= y_down_next;
            drawing_reg     <= drawing_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pixel_valid_reg <= pixel_valid_next;
        pixel_x_reg     <= pixel_x_next;
        pixel_y_reg     <= pixel_y_next;
        last_reg        <= last_next;
    end

    assign pix.valid       = out_valid_reg;
    assign pix.pixel_valid = pixel_valid_reg;
    assign pix.pixel_x     = pixel_x_reg;
    assign pix.pixel_y     = pixel_y_reg;
    assign pix.last_pixel  = last_reg;

endmodule

FILE: design/midpoint_line_raster.sv
// Top level of the midpoint line rasterizer.
// The cmd channel takes items: operation 0 loads a segment from two signed
// endpoints, operation 1 asks for the next pixel of the current segment.
// Every item gives exactly one result item on the pix channel, in order.
// A load, or a step with no segment in progress, gives a result with
// pixel_valid low and all other fields zero. A step on an active segment
// gives the next pixel, with last_pixel high on the segment's final endpoint.
// An accepted item is registered in the setup stage of the front end, then
// written into the queue, then popped into the output register of the back
// end, where its result appears.
// Throughput is one item per cycle while pix.ready is not held low, with the
// back end's add-and-compare step on the decision value done for each item.
// A four-entry queue sits between the front and back ends. When the receiver
// holds pix.ready low, the output register keeps its result, the queue fills,
// and cmd.ready falls once the queue and the setup stage are both full.
// Reset empties the queue and the output register and leaves no segment
// loaded; the first result after reset comes from the first accepted item.
module midpoint_line_raster (
    input  logic   clk,
    input  logic   rst_n,
    mlr_in_if.sink cmd,
    mlr_out_if.source pix
);
    import mlr_pkg::*;

    logic     q_wr_valid, q_wr_ready;
    seg_cmd_t q_wr_data;
    logic     q_rd_valid, q_rd_ready;
    seg_cmd_t q_rd_data;

    mlr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .wr_valid (q_wr_valid),
        .wr_ready (q_wr_ready),
        .wr_data  (q_wr_data)
    );

    mlr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (q_wr_valid),
        .wr_ready (q_wr_ready),
        .wr_data  (q_wr_data),
        .rd_valid (q_rd_valid),
        .rd_ready (q_rd_ready),
        .rd_data  (q_rd_data)
    );

    mlr_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_valid (q_rd_valid),
        .rd_ready (q_rd_ready),
        .rd_data  (q_rd_data),
        .pix      (pix)
    );

`ifndef ASSERT_OFF
    property p_blank_result_is_zero;
        @(posedge clk) disable iff (!rst_n)
        (pix.valid && !pix.pixel_valid) |->
            (pix.pixel_x == '0 && pix.pixel_y == '0 && !pix.last_pixel);
    endproperty
    a_blank_result_is_zero: assert property (p_blank_result_is_zero)
        else $error("Result without a pixel carries nonzero fields.");

    property p_last_needs_pixel;
        @(posedge clk) disable iff (!rst_n)
        (pix.valid && pix.last_pixel) |-> pix.pixel_valid;
    endproperty
    a_last_needs_pixel: assert property (p_last_needs_pixel)
        else $error("Last-pixel flag set on a result without a pixel.");

    property p_load_gives_blank;
        @(posedge clk) disable iff (!rst_n)
        (q_rd_valid && q_rd_ready && !q_rd_data.is_step) |=>
            (pix.valid && !pix.pixel_valid);
    endproperty
    a_load_gives_blank: assert property (p_load_gives_blank)
        else $error("A load item did not produce a blank result.");
`endif

endmodule

FILE: tb/midpoint_line_raster_test.sv
// Self-checking testbench for the midpoint line rasterizer with a predicting scoreboard.
`timescale 1ns / 100ps

module midpoint_line_raster_test;
    import mlr_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int ITEM_TARGET = 1450;
    localparam int MAX_REPORTS = 20;

    typedef struct packed {
        logic   pixel_valid;
        coord_t pixel_x;
        coord_t pixel_y;
        logic   last_pixel;
    } pixel_t;

    class pixel_scoreboard;
        coord_t cur_x;
        coord_t cur_y;
        coord_t major_end;
        dec_t   decision;
        dec_t   step_inc;
        dec_t   stay_dec;
        logic   steep;
        logic   y_down;
        logic   drawing;
        pixel_t expected_pixels[$];
        int     errors;
        int     loads;
        int     drawn;
        int     ends;

        function new();
            cur_x = '0;
            cur_y = '0;
            major_end = '0;
            decision = '0;
            step_inc = '0;
            stay_dec = '0;
            steep = 1'b0;
            y_down = 1'b0;
            drawing = 1'b0;
            errors = 0;
            loads = 0;
            drawn = 0;
            ends = 0;
        endfunction

        function void note_command(logic op, coord_t xs, coord_t ys, coord_t xe,
                                   coord_t ye);
            pixel_t px;
            coord_t xa;
            coord_t ya;
            coord_t xb;
            coord_t yb;
            int     dx;
            int     dy;
            int     ady;
            logic   at_end;
            px = '0;
            if (op == OP_LOAD)
            begin
                loads++;
                xa = xs;
                ya = ys;
                xb = xe;
                yb = ye;
                if (xa > xb)
                begin
                    xa = xe;
                    ya = ye;
                    xb = xs;
                    yb = ys;
                end
                dx = int'(xb) - int'(xa);
                dy = int'(yb) - int'(ya);
                ady = (dy < 0) ? -dy : dy;
                cur_x = xa;
                cur_y = ya;
                y_down = (dy < 0);
                steep = (ady > dx);
                if (steep)
                begin
                    major_end = yb;
                    decision = dec_t'(ady - 2 * dx);
                    step_inc = dec_t'(2 * ady - 2 * dx);
                    stay_dec = dec_t'(2 * dx);
                end
                else
                begin
                    major_end = xb;
                    decision = dec_t'(dx - 2 * ady);
                    step_inc = dec_t'(2 * dx - 2 * ady);
                    stay_dec = dec_t'(2 * ady);
                end
                drawing = 1'b1;
            end
            else if (drawing)
            begin
                at_end = ((steep ? cur_y : cur_x) == major_end);
                px.pixel_valid = 1'b1;
                px.pixel_x = cur_x;
                px.pixel_y = cur_y;
                px.last_pixel = at_end;
                if (at_end)
                begin
                    drawing = 1'b0;
                end
                else if (steep)
                begin
                    cur_y = coord_t'(cur_y + (y_down ? -1 : 1));
                    if (decision < 0)
                    begin
                        cur_x = coord_t'(cur_x + 1);
                        decision = dec_t'(decision + step_inc);
                    end
                    else
                    begin
                        decision = dec_t'(decision - stay_dec);
                    end
                end
                else
                begin
                    cur_x = coord_t'(cur_x + 1);
                    if (decision < 0)
                    begin
                        cur_y = coord_t'(cur_y + (y_down ? -1 : 1));
                        decision = dec_t'(decision + step_inc);
                    end
                    else
                    begin
                        decision = dec_t'(decision - stay_dec);
                    end
                end
            end
            expected_pixels.push_back(px);
        endfunction

        function void check_pixel(pixel_t got);
            pixel_t want;
            if (expected_pixels.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected result valid=%0b x=%0d y=%0d last=%0b", $time,
                             got.pixel_valid, got.pixel_x, got.pixel_y, got.last_pixel);
                return;
            end
            want = expected_pixels.pop_front();
            if (want.pixel_valid)
            begin
                drawn++;
                if (want.last_pixel)
                    ends++;
            end
            if (got.pixel_valid !== want.pixel_valid || got.pixel_x !== want.pixel_x ||
                got.pixel_y !== want.pixel_y || got.last_pixel !== want.last_pixel)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display({"%0t: expected valid=%0b x=%0d y=%0d last=%0b, ",
                              "got valid=%0b x=%0d y=%0d last=%0b"},
                             $time, want.pixel_valid, want.pixel_x, want.pixel_y,
                             want.last_pixel, got.pixel_valid, got.pixel_x, got.pixel_y,
                             got.last_pixel);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   cycle_count = 0;
    int   sent_count = 0;
    int   result_count = 0;

    mlr_in_if  cmd ();
    mlr_out_if pix ();

    pixel_scoreboard sb = new();

    midpoint_line_raster dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .pix   (pix)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic sender_calm();
        return sent_count >= 600 && sent_count < 900;
    endfunction

    task automatic send_item(logic op, coord_t xs, coord_t ys, coord_t xe, coord_t ye);
        if (!sender_calm() && $urandom_range(0, 99) < 5)
        begin
            cmd.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        cmd.valid <= 1'b1;
        cmd.operation <= op;
        cmd.x_start <= xs;
        cmd.y_start <= ys;
        cmd.x_end <= xe;
        cmd.y_end <= ye;
        @(posedge clk);
        while (!cmd.ready) @(posedge clk);
        sb.note_command(op, xs, ys, xe, ye);
        sent_count++;
    endtask

    task automatic draw_segment(coord_t xs, coord_t ys, coord_t xe, coord_t ye, int steps);
        send_item(OP_LOAD, xs, ys, xe, ye);
        repeat (steps)
            send_item(OP_STEP, coord_t'($urandom), coord_t'($urandom),
                      coord_t'($urandom), coord_t'($urandom));
    endtask

    task automatic draw_random_segment();
        int dx;
        int dy;
        int xa;
        int ya;
        int len;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 83)
        begin
            dx = $urandom_range(0, 12);
            dy = int'($urandom_range(0, 24)) - 12;
            xa = int'($urandom_range(0, 4095 - dx)) - 2048;
            ya = int'($urandom_range((dy < 0) ? -dy : 0, 4095 - ((dy > 0) ? dy : 0))) - 2048;
            len = ((dx > ((dy < 0) ? -dy : dy)) ? dx : ((dy < 0) ? -dy : dy)) + 1;
            if ($urandom_range(0, 9) == 0)
                len = $urandom_range(0, len - 1);
            else
                len = len + $urandom_range(0, 2);
            if ($urandom_range(0, 1))
                draw_segment(coord_t'(xa), coord_t'(ya), coord_t'(xa + dx), coord_t'(ya + dy),
                             len);
            else
                draw_segment(coord_t'(xa + dx), coord_t'(ya + dy), coord_t'(xa), coord_t'(ya),
                             len);
        end
        else if (pick < 95)
        begin
            draw_segment(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                         coord_t'($urandom), $urandom_range(0, 40));
        end
        else
        begin
            send_item(OP_STEP, coord_t'($urandom), coord_t'($urandom),
                      coord_t'($urandom), coord_t'($urandom));
        end
    endtask

    initial
    begin
        int stall_left;
        int pause_left;
        stall_left = 0;
        pause_left = 0;
        pix.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pix.valid && pix.ready)
            begin
                sb.check_pixel(pixel_t'{pix.pixel_valid, pix.pixel_x, pix.pixel_y,
                                        pix.last_pixel});
                result_count++;
                if (result_count == 200 || result_count == 1000)
                    pause_left = 80;
            end
            if (pause_left > 0)
            begin
                pause_left--;
                pix.ready <= 1'b0;
            end
            else if (result_count >= 600 && result_count < 900)
            begin
                pix.ready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                pix.ready <= 1'b0;
            end
            else if ($urandom_range(0, 99) < 5)
            begin
                stall_left = $urandom_range(0, 3);
                pix.ready <= 1'b0;
            end
            else
            begin
                pix.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        cmd.valid <= 1'b0;
        cmd.operation <= OP_LOAD;
        cmd.x_start <= '0;
        cmd.y_start <= '0;
        cmd.x_end <= '0;
        cmd.y_end <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(OP_STEP, -12'sd2048, 12'sd2047, -12'sd1, 12'sd0);
        draw_segment(12'sd2047, 12'sd2047, 12'sd2047, 12'sd2047, 2);
        draw_segment(-12'sd2048, -12'sd2048, 12'sd2047, 12'sd2047, 2);
        draw_segment(12'sd0, 12'sd0, 12'sd1, 12'sd3, 4);
        draw_segment(12'sd1, -12'sd3, 12'sd0, 12'sd0, 4);
        draw_segment(-12'sd3, 12'sd2, 12'sd0, 12'sd1, 4);
        draw_segment(-12'sd2048, 12'sd2047, -12'sd2048, 12'sd2045, 3);

        while (sent_count < ITEM_TARGET)
            draw_random_segment();
        cmd.valid <= 1'b0;

        while (sb.expected_pixels.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.expected_pixels.size() != 0)
        begin
            sb.errors++;
            $display("%0t: %0d expected results never arrived", $time,
                     sb.expected_pixels.size());
        end

        $display("Sent %0d items (%0d segment loads); checked %0d results,", sent_count,
                 sb.loads, result_count);
        $display("of which %0d were drawn pixels and %0d segment ends.", sb.drawn, sb.ends);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: sim.f
design/mlr_pkg.sv
design/mlr_in_if.sv
design/mlr_out_if.sv
design/mlr_front.sv
design/mlr_queue.sv
design/mlr_back.sv
design/midpoint_line_raster.sv
tb/midpoint_line_raster_test.sv
